@@ sv/blcm_pkg.sv @@
// ----------------------------------------------------------------------------
// blcm_pkg: shared types and codes of the bounds-checked linear memory
// Operation and status codes, controller commands, datapath status.
// ----------------------------------------------------------------------------
`default_nettype none

package blcm_pkg;

	// operation codes
	localparam logic [2:0] OP_LOAD  = 3'd0;
	localparam logic [2:0] OP_STORE = 3'd1;
	localparam logic [2:0] OP_GROW  = 3'd2;
	localparam logic [2:0] OP_SIZE  = 3'd3;
	localparam logic [2:0] OP_FILL  = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_OOB     = 2'd1;
	localparam logic [1:0] ST_REFUSED = 2'd2;

	// configuration register indexes
	localparam logic REG_RESERVED = 1'b0;
	localparam logic REG_INITIAL  = 1'b1;

	localparam int MAX_ACCESS_BYTES = 8;

	// commands from controller to datapath
	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_CHECK,
		CMD_STEP,
		CMD_SCAN_START,
		CMD_SCAN_NEXT,
		CMD_CLEAR_START,
		CMD_FINISH
	} cmd_t;

	// what the byte walk does
	typedef enum logic [2:0] {
		MODE_NONE,
		MODE_LOAD,
		MODE_STORE,
		MODE_FILL,
		MODE_CLEAR
	} mode_t;

	// status from datapath to controller
	typedef struct packed {
		mode_t mode;
		logic  rem_zero;
		logic  scan_req;
		logic  scan_hit;
		logic  scan_last;
		logic  out_free;
	} stat_t;

endpackage

`default_nettype wire

@@ sv/blcm_ctrl.sv @@
// ----------------------------------------------------------------------------
// blcm_ctrl: sequencing controller
// Walks each request through check, byte walk and result, and runs the
// page clearing scan whenever stale pages may have become live.
// ----------------------------------------------------------------------------
`default_nettype none

module blcm_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire blcm_pkg::stat_t st,
	output blcm_pkg::cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_XFER,
		S_WAIT,
		S_FINISH
	} state_t;

	state_t state_q;

	// requests are taken only when no clearing scan is due
	assign in_ready = (state_q == S_IDLE) && !st.scan_req;

	// command decode
	always_comb begin
		cmd = blcm_pkg::CMD_NONE;
		unique case (state_q)
			S_IDLE:   if (st.scan_req) cmd = blcm_pkg::CMD_SCAN_START;
			S_CHECK:  cmd = blcm_pkg::CMD_CHECK;
			S_SCAN:   cmd = st.scan_hit ? blcm_pkg::CMD_CLEAR_START : blcm_pkg::CMD_SCAN_NEXT;
			S_XFER: begin
				if (!st.rem_zero) cmd = blcm_pkg::CMD_STEP;
				else if (st.mode == blcm_pkg::MODE_CLEAR) cmd = blcm_pkg::CMD_SCAN_NEXT;
			end
			S_WAIT:   cmd = blcm_pkg::CMD_NONE;
			S_FINISH: if (st.out_free) cmd = blcm_pkg::CMD_FINISH;
			default:  cmd = blcm_pkg::CMD_NONE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (st.scan_req) state_q <= S_SCAN;
					else if (in_valid) state_q <= S_CHECK;
				end
				S_CHECK: state_q <= S_XFER;
				S_SCAN: begin
					if (st.scan_hit) state_q <= S_XFER;
					else if (st.scan_last) state_q <= S_IDLE;
				end
				S_XFER: begin
					if (st.rem_zero) begin
						priority case (st.mode)
							blcm_pkg::MODE_CLEAR: state_q <= st.scan_last ? S_IDLE : S_SCAN;
							blcm_pkg::MODE_LOAD:  state_q <= S_WAIT;
							default:              state_q <= S_FINISH;
						endcase
					end
				end
				S_WAIT:   state_q <= S_FINISH;
				S_FINISH: if (st.out_free) state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ sv/blcm_dp.sv @@
// ----------------------------------------------------------------------------
// blcm_dp: memory datapath
// Byte memory, watermark and registers, bounds check, byte walk counters,
// load assembly with extension, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module blcm_dp #(
	parameter int MAX_PAGES       = 4,
	parameter int PAGE_SIZE_BYTES = 65536
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	// request capture
	input  wire logic            take,
	input  wire logic [2:0]      operation,
	input  wire logic [63:0]     address,
	input  wire logic [3:0]      byte_count,
	input  wire logic            sign_flag,
	input  wire logic [6:0]      ext_width,
	input  wire logic [63:0]     store_value,
	input  wire logic [18:0]     fill_count,
	input  wire logic [31:0]     delta_pages,
	// configuration
	input  wire logic            cfg_we,
	input  wire logic            cfg_idx,
	input  wire logic [2:0]      cfg_data,
	output logic [2:0]           reserved_pages,
	output logic [2:0]           initial_pages,
	// control
	input  wire blcm_pkg::cmd_t  cmd,
	output blcm_pkg::stat_t      st,
	// result
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [1:0]           out_status,
	output logic [63:0]          out_value
);

	localparam int MEM_DEPTH = MAX_PAGES * PAGE_SIZE_BYTES;
	localparam int MAW       = $clog2(MEM_DEPTH);
	localparam int RMW       = $clog2(MEM_DEPTH + 1);
	localparam int PGW       = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

	logic [7:0] mem [MEM_DEPTH];

	// captured request
	logic [2:0]  op_q;
	logic [63:0] addr_q;
	logic [3:0]  nbytes_q;
	logic        sgn_q;
	logic [6:0]  rw_q;
	logic [63:0] val_q;
	logic [18:0] fcnt_q;
	logic [31:0] delta_q;

	// state and walk
	logic [2:0]           reserved_q, initial_q, live_q;
	logic [MAX_PAGES-1:0] stale_q;
	logic                 scan_req_q;
	logic [PGW-1:0]       page_q;
	blcm_pkg::mode_t      mode_q;
	logic [MAW-1:0]       ptr_q;
	logic [RMW-1:0]       rem_q;
	logic [63:0]          sh_q;
	logic [7:0]           rd_q;
	logic                 rd_pend_q;
	logic [1:0]           res_st_q;
	logic [63:0]          res_val_q;
	logic                 out_valid_q;
	logic [1:0]           out_st_q;
	logic [63:0]          out_val_q;

	assign reserved_pages = reserved_q;
	assign initial_pages  = initial_q;
	assign out_valid      = out_valid_q;
	assign out_status     = out_st_q;
	assign out_value      = out_val_q;

	// clamp of a register page count to the store size
	logic [2:0] init_clamp, ceil_clamp;
	assign init_clamp = (9'(cfg_data) > 9'(MAX_PAGES)) ? 3'(MAX_PAGES) : cfg_data;
	assign ceil_clamp = (9'(reserved_q) > 9'(MAX_PAGES)) ? 3'(MAX_PAGES) : reserved_q;

	// bounds check against the live size
	logic [63:0] lim, n_chk;
	logic        is_mem_op, oob;
	assign lim       = 64'(32'(live_q) * 32'(PAGE_SIZE_BYTES));
	assign is_mem_op = (op_q == blcm_pkg::OP_LOAD) || (op_q == blcm_pkg::OP_STORE);
	assign n_chk     = is_mem_op ? 64'(nbytes_q) : 64'(fcnt_q);
	assign oob       = (addr_q > lim) || (n_chk > (lim - addr_q)) ||
	                   (is_mem_op && (nbytes_q > 4'(blcm_pkg::MAX_ACCESS_BYTES)));

	// grow check
	logic [32:0] grow_sum;
	logic        grow_bad;
	assign grow_sum = 33'(live_q) + {1'b0, delta_q};
	assign grow_bad = delta_q[31] || (grow_sum > 33'(ceil_clamp));

	// scan status
	logic scan_hit;
	assign scan_hit = stale_q[page_q] && (9'(page_q) < 9'(live_q));

	// load assembly and sign extension
	logic [6:0]  sb;
	logic [63:0] ld_v, ext, ld_res;
	always_comb begin
		sb     = {nbytes_q, 3'b000};
		ld_v   = sh_q >> (7'd64 - sb);
		ext    = ~64'd0 << sb;
		if (rw_q < 7'd64) ext = ext & ((64'd1 << rw_q) - 64'd1);
		ld_res = ld_v;
		if (sgn_q && (sb != 7'd0) && (rw_q > sb) && ld_v[sb[5:0] - 6'd1]) ld_res = ld_v | ext;
	end

	assign st.mode      = mode_q;
	assign st.rem_zero  = (rem_q == '0);
	assign st.scan_req  = scan_req_q;
	assign st.scan_hit  = scan_hit;
	assign st.scan_last = (32'(page_q) == MAX_PAGES - 1);
	assign st.out_free  = !out_valid_q || out_ready;

	// memory port
	logic       we;
	logic [7:0] wdata;
	assign we = (cmd == blcm_pkg::CMD_STEP) && (rem_q != '0) &&
	            ((mode_q == blcm_pkg::MODE_STORE) || (mode_q == blcm_pkg::MODE_FILL) ||
	             (mode_q == blcm_pkg::MODE_CLEAR));
	assign wdata = (mode_q == blcm_pkg::MODE_CLEAR) ? 8'h00 : sh_q[7:0];

	always_ff @(posedge clk) begin
		if (we) mem[ptr_q] <= wdata;
		rd_q <= mem[ptr_q];
	end

	// request capture
	always_ff @(posedge clk) begin
		if (take) begin
			op_q     <= operation;
			addr_q   <= address;
			nbytes_q <= byte_count;
			sgn_q    <= sign_flag;
			rw_q     <= ext_width;
			val_q    <= store_value;
			fcnt_q   <= fill_count;
			delta_q  <= delta_pages;
		end
	end

	// walk, check and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q  <= 3'd4;
			initial_q   <= 3'd1;
			live_q      <= (9'd1 > 9'(MAX_PAGES)) ? 3'(MAX_PAGES) : 3'd1;
			stale_q     <= '1;
			scan_req_q  <= 1'b1;
			page_q      <= '0;
			mode_q      <= blcm_pkg::MODE_NONE;
			rem_q       <= '0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_q <= (cmd == blcm_pkg::CMD_STEP) && (mode_q == blcm_pkg::MODE_LOAD);
			if (out_valid_q && out_ready && (cmd != blcm_pkg::CMD_FINISH))
				out_valid_q <= 1'b0;
			if (rd_pend_q) sh_q <= {rd_q, sh_q[63:8]};

			unique case (cmd)
				blcm_pkg::CMD_CHECK: begin
					res_st_q  <= blcm_pkg::ST_OK;
					res_val_q <= '0;
					mode_q    <= blcm_pkg::MODE_NONE;
					rem_q     <= '0;
					ptr_q     <= addr_q[MAW-1:0];
					sh_q      <= (op_q == blcm_pkg::OP_LOAD) ? 64'd0 : val_q;
					priority case (op_q)
						blcm_pkg::OP_LOAD, blcm_pkg::OP_STORE, blcm_pkg::OP_FILL: begin
							if (oob) begin
								res_st_q <= blcm_pkg::ST_OOB;
							end else begin
								rem_q  <= RMW'(n_chk);
								mode_q <= (op_q == blcm_pkg::OP_LOAD) ? blcm_pkg::MODE_LOAD :
								          (op_q == blcm_pkg::OP_STORE) ? blcm_pkg::MODE_STORE :
								          blcm_pkg::MODE_FILL;
							end
						end
						blcm_pkg::OP_GROW: begin
							if (grow_bad) begin
								res_st_q  <= blcm_pkg::ST_REFUSED;
								res_val_q <= '1;
							end else begin
								res_val_q  <= 64'(live_q);
								live_q     <= grow_sum[2:0];
								scan_req_q <= 1'b1;
							end
						end
						blcm_pkg::OP_SIZE: res_val_q <= 64'(live_q);
						default: ;
					endcase
				end
				blcm_pkg::CMD_STEP: begin
					rem_q <= rem_q - RMW'(1);
					ptr_q <= ptr_q + MAW'(1);
					if (mode_q == blcm_pkg::MODE_STORE) sh_q <= sh_q >> 8;
				end
				blcm_pkg::CMD_SCAN_START: begin
					page_q     <= '0;
					scan_req_q <= 1'b0;
				end
				blcm_pkg::CMD_SCAN_NEXT: page_q <= page_q + PGW'(1);
				blcm_pkg::CMD_CLEAR_START: begin
					mode_q          <= blcm_pkg::MODE_CLEAR;
					ptr_q           <= MAW'(MAW'(page_q) * MAW'(PAGE_SIZE_BYTES));
					rem_q           <= RMW'(PAGE_SIZE_BYTES);
					stale_q[page_q] <= 1'b0;
				end
				blcm_pkg::CMD_FINISH: begin
					out_valid_q <= 1'b1;
					out_st_q    <= res_st_q;
					out_val_q   <= (mode_q == blcm_pkg::MODE_LOAD) ? ld_res : res_val_q;
				end
				default: ;
			endcase

			// configuration writes
			if (cfg_we) begin
				if (cfg_idx == blcm_pkg::REG_RESERVED) begin
					reserved_q <= cfg_data;
				end else begin
					initial_q  <= cfg_data;
					live_q     <= init_clamp;
					scan_req_q <= 1'b1;
					for (int p = 0; p < MAX_PAGES; p++)
						if (p >= int'(init_clamp)) stale_q[p] <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/bounds_checked_linear_memory_core.sv @@
// ----------------------------------------------------------------------------
// bounds_checked_linear_memory_core: paged byte memory with live size
// Load, store, grow, size query and fill; accesses checked against the watermark.
// ----------------------------------------------------------------------------
//  channel  | direction | transaction
//  s_axis   | in        | one request (operation in tuser)
//  m_axis   | out       | one result (status in tuser)
//  apb      | in/out    | register write or read
//
// Requests are taken only while the controller is idle, so each one runs through
// to its result before the next is accepted; loads, stores and fills move their
// bytes one at a time through the single byte-wide memory port.
// After reset, and after a grow or initial_pages write, no request is taken while
// live pages not yet cleared are swept one byte a cycle: the scan starts, then steps
// through each page in turn and clears every live stale page of PAGE_SIZE_BYTES.
// A result waiting on m_axis blocks only the next result, not the next request.
// ----------------------------------------------------------------------------
`default_nettype none

module bounds_checked_linear_memory_core #(
	parameter int MAX_PAGES       = 4,
	parameter int PAGE_SIZE_BYTES = 65536
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// request stream
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// address[63:0], byte_count[67:64], sign_flag[68], ext_width[75:69],
	// store_value[139:76], fill_count[158:140], delta_pages[190:159], zero[191]
	input  wire logic [191:0] s_axis_tdata,
	// operation[2:0]
	input  wire logic [2:0]   s_axis_tuser,
	// result stream
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// result_value[63:0]
	output logic [63:0]       m_axis_tdata,
	// status[1:0]
	output logic [1:0]        m_axis_tuser,
	// register port
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	blcm_pkg::cmd_t  cmd;
	blcm_pkg::stat_t st;
	logic            in_ready;
	logic [2:0]      reserved_pages, initial_pages;

	assign s_axis_tready = in_ready;
	assign pready        = 1'b1;

	// register read back
	assign prdata = (paddr[2] == blcm_pkg::REG_INITIAL) ? {29'd0, initial_pages} :
	                                                    {29'd0, reserved_pages};

	blcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	blcm_dp #(
		.MAX_PAGES       (MAX_PAGES),
		.PAGE_SIZE_BYTES (PAGE_SIZE_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (s_axis_tvalid && in_ready),
		.operation      (s_axis_tuser),
		.address        (s_axis_tdata[63:0]),
		.byte_count     (s_axis_tdata[67:64]),
		.sign_flag      (s_axis_tdata[68]),
		.ext_width      (s_axis_tdata[75:69]),
		.store_value    (s_axis_tdata[139:76]),
		.fill_count     (s_axis_tdata[158:140]),
		.delta_pages    (s_axis_tdata[190:159]),
		.cfg_we         (psel && penable && pwrite),
		.cfg_idx        (paddr[2]),
		.cfg_data       (pwdata[2:0]),
		.reserved_pages (reserved_pages),
		.initial_pages  (initial_pages),
		.cmd            (cmd),
		.st             (st),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_status     (m_axis_tuser),
		.out_value      (m_axis_tdata)
	);

endmodule

`default_nettype wire
